// ===== hdl/skq_pkg.sv =====
// ----------------------------------------------------------------------------
// skq_pkg
// Shared types and codes for the sorted key queue.
// ----------------------------------------------------------------------------
package skq_pkg;

  localparam int ID_W    = 16;
  localparam int KEY_W   = 24;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;
  localparam int ENTRY_W = ID_W + KEY_W;

  // command codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // result codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_INVALID   = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CMP  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

endpackage

// ===== hdl/sorted_key_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_key_queue
// Queue of id/key entries kept in ascending key order, with insert,
// remove-by-id and search-by-id commands walked over a single RAM.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake           Payload
// in_      in   in_tvalid/tready    op, entry_id, entry_key (one command)
// out_     out  out_tvalid/tready   status, count (one result per command)
//
// Walk: each entry visited takes a RAM read, then a compare and write back.
//   Insert walks down from the tail; remove and search walk up from the head.
//   Full, invalid and unused codes go straight to the result.
// Reset: count and control only; entries above the count are never read.
// Stalls: in_tready only while idle; a held result lets the next command in.
// ----------------------------------------------------------------------------
module sorted_key_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [1:0] op, [17:2] entry_id, [41:18] entry_key, rest 0
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [1:0] status, [6:2] count, [7] 0
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  // command fields
  logic [skq_pkg::OP_W-1:0]  in_op;
  logic [skq_pkg::ID_W-1:0]  in_id;
  logic [skq_pkg::KEY_W-1:0] in_key;

  // sequencer state
  skq_pkg::state_t             state_r, state_nxt;
  logic [skq_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [skq_pkg::ID_W-1:0]    id_r, id_nxt;
  logic [skq_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [CNT_W-1:0]            pos_r, pos_nxt;   // walk position
  logic                        found_r, found_nxt;
  logic [skq_pkg::STAT_W-1:0]  stat_r, stat_nxt;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic [skq_pkg::STAT_W-1:0]  out_stat_r, out_stat_nxt;
  logic [skq_pkg::COUNT_W-1:0] out_cnt_r, out_cnt_nxt;

  // RAM port
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  skq_pkg::entry_t       ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  skq_pkg::entry_t       ram_rdata;
  logic [CNT_W-1:0]      pos_dec;

  assign in_op  = in_tdata[1:0];
  assign in_id  = in_tdata[17:2];
  assign in_key = in_tdata[41:18];

  assign in_tready  = (state_r == skq_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_stat_r};

  assign pos_dec = pos_r - CNT_W'(1);

  skq_ram #(
    .WIDTH (skq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    key_nxt       = key_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    found_nxt     = found_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r;
    out_stat_nxt  = out_stat_r;
    out_cnt_nxt   = out_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r[IDX_W-1:0];
    ram_wdata     = '{id: id_r, key: key_r};
    // insert walks downwards and reads the entry below the slot
    ram_raddr     = (op_r == skq_pkg::OP_INSERT) ? pos_dec[IDX_W-1:0] : pos_r[IDX_W-1:0];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      skq_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_op;
          id_nxt    = in_id;
          key_nxt   = in_key;
          found_nxt = 1'b0;
          state_nxt = skq_pkg::S_RD;
          case (in_op)
            skq_pkg::OP_INSERT: begin
              pos_nxt = cnt_r;
              if (cnt_r >= DEPTH_C) begin
                stat_nxt  = skq_pkg::ST_FULL;
                state_nxt = skq_pkg::S_DONE;
              end
            end
            skq_pkg::OP_REMOVE: begin
              pos_nxt = '0;
              if (in_id == '0) begin
                stat_nxt  = skq_pkg::ST_INVALID;
                state_nxt = skq_pkg::S_DONE;
              end
            end
            skq_pkg::OP_SEARCH: begin
              pos_nxt = '0;
              if (cnt_r == '0) begin
                stat_nxt  = skq_pkg::ST_INVALID;
                state_nxt = skq_pkg::S_DONE;
              end
            end
            default: begin
              stat_nxt  = skq_pkg::ST_INVALID;
              state_nxt = skq_pkg::S_DONE;
            end
          endcase
        end
      end

      skq_pkg::S_RD: begin
        if (op_r == skq_pkg::OP_INSERT) begin
          if (pos_r == '0) begin
            // reached the head: new entry goes first
            ram_we    = 1'b1;
            cnt_nxt   = cnt_r + CNT_W'(1);
            stat_nxt  = skq_pkg::ST_OK;
            state_nxt = skq_pkg::S_DONE;
          end else begin
            state_nxt = skq_pkg::S_CMP;
          end
        end else if (pos_r == cnt_r) begin
          // end of the walk
          state_nxt = skq_pkg::S_DONE;
          if (found_r) begin
            cnt_nxt  = cnt_r - CNT_W'(1);
            stat_nxt = skq_pkg::ST_OK;
          end else begin
            stat_nxt = skq_pkg::ST_NOT_FOUND;
          end
        end else begin
          state_nxt = skq_pkg::S_CMP;
        end
      end

      skq_pkg::S_CMP: begin
        state_nxt = skq_pkg::S_RD;
        if (op_r == skq_pkg::OP_INSERT) begin
          ram_we = 1'b1;
          if (ram_rdata.key < key_r) begin
            // slot found above a smaller key
            cnt_nxt   = cnt_r + CNT_W'(1);
            stat_nxt  = skq_pkg::ST_OK;
            state_nxt = skq_pkg::S_DONE;
          end else begin
            // move the entry up one place
            ram_wdata = ram_rdata;
            pos_nxt   = pos_dec;
          end
        end else begin
          pos_nxt = pos_r + CNT_W'(1);
          if (found_r) begin
            // close the gap left by the removed entry
            ram_we    = 1'b1;
            ram_waddr = pos_dec[IDX_W-1:0];
            ram_wdata = ram_rdata;
          end else if (ram_rdata.id == id_r) begin
            found_nxt = 1'b1;
            if (op_r == skq_pkg::OP_SEARCH) begin
              stat_nxt  = skq_pkg::ST_OK;
              state_nxt = skq_pkg::S_DONE;
            end
          end
        end
      end

      skq_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = stat_r;
          out_cnt_nxt   = skq_pkg::COUNT_W'(cnt_r);
          state_nxt     = skq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = skq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skq_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    key_r      <= key_nxt;
    pos_r      <= pos_nxt;
    found_r    <= found_nxt;
    stat_r     <= stat_nxt;
    out_stat_r <= out_stat_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count above queue depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (cnt_r != $past(cnt_r)) |-> (state_r == skq_pkg::S_DONE))
    else $error("entry count changed outside command completion");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skq_pkg::S_RD || state_r == skq_pkg::S_CMP) |-> (pos_r <= cnt_r))
    else $error("walk position beyond entry count");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skq_pkg::S_DONE && stat_r == skq_pkg::ST_FULL) |-> (cnt_r == DEPTH_C))
    else $error("full reported on a queue that is not full");
`endif

endmodule

// ===== hdl/skq_ram.sv =====
// ----------------------------------------------------------------------------
// skq_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module skq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/skq_sb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skq_sb_pkg
// Scoreboard for the sorted key queue: keeps its own copy of the held
// entries, works out the status and count of every command taken in, and
// checks each result transfer against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
package skq_sb_pkg;

  import skq_pkg::*;

  localparam int HELD_MAX = 16;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  class skq_scoreboard;

    typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [COUNT_W-1:0] count;
    } result_t;

    logic [ID_W-1:0]  held_ids  [HELD_MAX];
    logic [KEY_W-1:0] held_keys [HELD_MAX];
    int unsigned      held_count;
    result_t          expected_q[$];
    int unsigned      mismatches;

    function new();
      held_count = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // position of first entry with this id, held_count if none
    function int unsigned find_id(logic [ID_W-1:0] id);
      for (int unsigned i = 0; i < held_count; i++)
        if (held_ids[i] == id) return i;
      return held_count;
    endfunction

    function void note_command(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                               logic [KEY_W-1:0] key);
      result_t     res;
      int unsigned pos;
      res.status = ST_INVALID;
      case (op)
        OP_INSERT: begin
          if (held_count >= HELD_MAX) begin
            res.status = ST_FULL;
          end else begin
            // lands ahead of any equal keys
            pos = 0;
            while (pos < held_count && held_keys[pos] < key) pos++;
            for (int unsigned i = held_count; i > pos; i--) begin
              held_ids[i]  = held_ids[i-1];
              held_keys[i] = held_keys[i-1];
            end
            held_ids[pos]  = id;
            held_keys[pos] = key;
            held_count++;
            res.status = ST_OK;
          end
        end
        OP_REMOVE: begin
          if (id != '0) begin
            pos = find_id(id);
            if (pos >= held_count) begin
              res.status = ST_NOT_FOUND;
            end else begin
              for (int unsigned i = pos; i + 1 < held_count; i++) begin
                held_ids[i]  = held_ids[i+1];
                held_keys[i] = held_keys[i+1];
              end
              held_count--;
              res.status = ST_OK;
            end
          end
        end
        OP_SEARCH: begin
          if (held_count != 0)
            res.status = (find_id(id) < held_count) ? ST_OK : ST_NOT_FOUND;
        end
        default: res.status = ST_INVALID;
      endcase
      res.count = held_count[COUNT_W-1:0];
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [STAT_W-1:0] status, logic [COUNT_W-1:0] count);
      result_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch("result transfer with no command outstanding");
        return;
      end
      exp = expected_q.pop_front();
      if (status !== exp.status)
        report_mismatch($sformatf("status %0d, expected %0d", status, exp.status));
      if (count !== exp.count)
        report_mismatch($sformatf("count %0d, expected %0d", count, exp.count));
    endtask

  endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_key_queue: a directed opener covering the
// corner commands, then random phases that fill, drain and churn the queue
// under random idling on both streams, long receiver hold-offs and full
// drain pauses. Results are checked in order against the scoreboard.
// ----------------------------------------------------------------------------
module tb;

  import skq_pkg::*;
  import skq_sb_pkg::*;

  localparam int ITEM_TARGET = 1700;
  localparam int HOLD_CYCLES = 300;  // receiver hold-off length
  localparam int TAIL_CYCLES = 50;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_CHURN} mix_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // [1:0] op, [17:2] entry_id, [41:18] entry_key, rest 0
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [1:0] status, [6:2] count, [7] 0

  skq_scoreboard sb = new();

  // stream idling controls; each written from the main process only
  bit tx_idle_en  = 1'b1;
  bit rx_idle_en  = 1'b1;
  bit hold_toggle = 1'b0;   // flipping this asks the receiver for a hold-off

  int items_sent = 0;

  always #10 clk = ~clk;

  sorted_key_queue #(.QUEUE_DEPTH(HELD_MAX)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // --------------------------------------------------------------------------
  // Monitors: sample at the rising edge, before this edge's updates land.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_command(in_tdata[1:0], in_tdata[17:2], in_tdata[41:18]);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[1:0], out_tdata[6:2]);
  end

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, plus a counted hold-off on request.
  // --------------------------------------------------------------------------
  initial begin : receiver
    bit hold_seen;
    int hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= !rx_idle_en || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: one command per call, returns at the edge of its transfer.
  // tvalid stays high across back-to-back commands.
  // --------------------------------------------------------------------------
  task automatic send_command(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                              input logic [KEY_W-1:0] key);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 99) < 25) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, key, id, op};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Small id pool so removes and searches mostly hit; small key range for ties.
  task automatic send_random(input mix_mode_t mode);
    int r;
    int ins_lim;
    int rem_lim;
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    case (mode)
      MODE_FILL:  begin ins_lim = 70; rem_lim = 85; end
      MODE_DRAIN: begin ins_lim = 20; rem_lim = 75; end
      default:    begin ins_lim = 45; rem_lim = 75; end
    endcase
    r = $urandom_range(0, 99);
    if (r < ins_lim)      op = OP_INSERT;
    else if (r < rem_lim) op = OP_REMOVE;
    else if (r < 97)      op = OP_SEARCH;
    else                  op = OP_UNUSED;
    r = $urandom_range(0, 99);
    if (r < 80)      id = ID_W'($urandom_range(1, 12));
    else if (r < 95) id = ID_W'($urandom);
    else             id = '0;
    r = $urandom_range(0, 99);
    if (r < 50)      key = KEY_W'($urandom_range(0, 15));
    else if (r < 90) key = KEY_W'($urandom);
    else if (r < 95) key = '0;
    else             key = '1;
    send_command(op, id, key);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int        phase;
    int        phase_len;
    mix_mode_t mode;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opener
    send_command(OP_SEARCH, 16'd1, 24'd0);           // search on empty: invalid
    send_command(OP_REMOVE, 16'd5, 24'd0);           // remove on empty: not found
    send_command(OP_REMOVE, 16'd0, 24'hFFFFFF);      // remove id zero: invalid
    send_command(OP_UNUSED, 16'd0, 24'd0);           // unused code: invalid
    send_command(OP_INSERT, 16'd1, 24'd100);
    send_command(OP_INSERT, 16'd2, 24'd0);           // lowest key
    send_command(OP_INSERT, 16'd3, 24'hFFFFFF);      // highest key
    send_command(OP_INSERT, 16'd4, 24'd100);         // equal key, goes ahead
    send_command(OP_INSERT, 16'd0, 24'd50);          // id zero is allowed on insert
    send_command(OP_INSERT, 16'hFFFF, 24'd100);
    send_command(OP_INSERT, 16'd1, 24'd7);           // duplicate id
    send_command(OP_SEARCH, 16'hFFFF, 24'hABCDEF);   // found, key ignored
    send_command(OP_SEARCH, 16'd0, 24'd0);           // search id zero: found
    send_command(OP_SEARCH, 16'h1234, 24'd0);        // not held
    send_command(OP_REMOVE, 16'd1, 24'd0);           // first match by position
    send_command(OP_REMOVE, 16'd4, 24'd0);
    send_command(OP_REMOVE, 16'd9, 24'd0);           // not held
    send_command(OP_UNUSED, 16'hFFFF, 24'hFFFFFF);   // unused code, all ones
    send_command(OP_REMOVE, 16'hFFFF, 24'd0);
    send_command(OP_SEARCH, 16'd1, 24'd0);           // remaining duplicate id

    // random phases
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      mode       = mix_mode_t'(phase % 3);
      phase_len  = $urandom_range(60, 120);
      tx_idle_en = (phase != 2);
      rx_idle_en = (phase != 2);
      if (phase == 4 || phase == 11) begin
        // receiver holds off while commands keep coming back to back
        tx_idle_en = 1'b0;
        hold_toggle <= ~hold_toggle;
      end
      if (phase % 5 == 3) begin
        // pause the sender until every result has been transferred
        in_tvalid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
      repeat (phase_len) send_random(mode);
      phase++;
    end

    // one edge first so the last transfer is already in the scoreboard
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() == 0 && sb.mismatches == 0)
      $display("PASS sorted_key_queue");
    else
      $display("FAIL sorted_key_queue");
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin : watchdog
    #20_000_000;
    $display("FAIL sorted_key_queue");
    $finish;
  end

endmodule
